[design/sxp_pkg.sv]
// Shared constants and the xorshift32 word update for the seeded permutation block.
// No dependencies; imported by sxp_mod_serial and seeded_xorshift_permutation.
package sxp_pkg;

  localparam int RNG_W               = 32;
  localparam int FIELD_W             = 3;
  // dividend bits consumed per cycle by the serial modulo unit
  localparam int DIGIT_W             = 4;
  localparam int DEFAULT_STAGE_COUNT = 8;

  localparam logic [RNG_W-1:0] SEED_MASK = 32'hDEADBEEF;
  localparam int               SHIFT_A   = 13;
  localparam int               SHIFT_B   = 17;
  localparam int               SHIFT_C   = 5;

  // one xorshift32 advance: left 13, right 17, left 5
  function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] w);
    logic [RNG_W-1:0] t;
    t = w ^ (w << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return t;
  endfunction

endpackage

[design/sxp_mod_serial.sv]
// Digit-serial unsigned modulo of a 32-bit word by a small divisor.
// Depends on sxp_pkg (RNG_W, DIGIT_W).
module sxp_mod_serial import sxp_pkg::*; #(
  parameter int STAGE_COUNT = DEFAULT_STAGE_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [RNG_W-1:0]                    dividend,
  input  logic [$clog2(STAGE_COUNT+1)-1:0]    divisor,
  output logic                                done,
  output logic [$clog2(STAGE_COUNT+1)-1:0]    remainder
);

  localparam int DIV_W  = $clog2(STAGE_COUNT + 1);
  localparam int N_ITER = RNG_W / DIGIT_W;
  localparam int CNT_W  = (N_ITER > 1) ? $clog2(N_ITER) : 1;

  logic [RNG_W-1:0] shreg;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] rem_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  // DIGIT_W restoring steps: shift in one dividend bit, subtract if it fits
  always_comb begin
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    r = rem;
    t = '0;
    for (int d = 0; d < DIGIT_W; d++) begin
      t = {r, shreg[RNG_W-1-d]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[DIV_W-1:0];
    end
    rem_next = r;
  end

  // control: count digits, flag the final one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(N_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out MSB first, remainder accumulates
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << DIGIT_W;
      rem   <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

[design/seeded_xorshift_permutation.sv]
// Seeded permutation generator: Fisher-Yates shuffle driven by xorshift32.
// From a seed, the block first fills the store with the identity, N = STAGE_COUNT,
// then per swap advances the rng, runs the serial modulo, and reads and writes the store.
// Entries then leave one at a time through a read state and an output state, holding on
// entry_ready; a new seed is taken once the last entry sits in the output register.
// Reset (sync, active high) idles the sequencer; the store is not cleared.
module seeded_xorshift_permutation import sxp_pkg::*; #(
  parameter int STAGE_COUNT = DEFAULT_STAGE_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               seed_valid,
  output logic               seed_ready,
  input  logic [RNG_W-1:0]   seed,
  output logic               entry_valid,
  input  logic               entry_ready,
  output logic [FIELD_W-1:0] position,
  output logic [FIELD_W-1:0] entry_value,
  output logic               last_entry
);

  localparam int IDX_W = $clog2(STAGE_COUNT);
  localparam int DIV_W = $clog2(STAGE_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STAGE_COUNT - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_RNG   = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_RDI   = 4'd4;
  localparam logic [3:0] S_RDJ   = 4'd5;
  localparam logic [3:0] S_WRI   = 4'd6;
  localparam logic [3:0] S_WRJ   = 4'd7;
  localparam logic [3:0] S_EMRD  = 4'd8;
  localparam logic [3:0] S_EMOUT = 4'd9;

  logic [3:0]         state;
  logic [RNG_W-1:0]   rng;
  logic [RNG_W-1:0]   rng_next;
  logic [RNG_W-1:0]   seed_word;
  logic [IDX_W-1:0]   step;
  logic [IDX_W-1:0]   j;
  logic [IDX_W-1:0]   k;
  logic [FIELD_W-1:0] held;
  logic [FIELD_W-1:0] rdata;
  logic [FIELD_W-1:0] perm_mem [STAGE_COUNT];
  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   waddr;
  logic [FIELD_W-1:0] wdata;
  logic               wen;
  logic               mod_start;
  logic               mod_done;
  logic [DIV_W-1:0]   mod_rem;
  logic               out_load;

  assign seed_ready = (state == S_IDLE);
  assign seed_word  = seed ^ SEED_MASK;
  assign rng_next   = xorshift32(rng);
  assign mod_start  = (state == S_RNG);
  assign out_load   = (state == S_EMOUT) && (!entry_valid || entry_ready);

  // modulo by i+1
  sxp_mod_serial #(
    .STAGE_COUNT (STAGE_COUNT)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (rng_next),
    .divisor   (DIV_W'(step) + 1'b1),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // store port selection
  always_comb begin
    raddr = step;
    waddr = step;
    wdata = rdata;
    wen   = 1'b0;
    unique case (state)
      S_INIT: begin
        waddr = k;
        wdata = FIELD_W'(k);
        wen   = 1'b1;
      end
      S_RDJ: raddr = j;
      S_WRI: wen = 1'b1;
      S_WRJ: begin
        waddr = j;
        wdata = held;
        wen   = 1'b1;
      end
      S_EMRD, S_EMOUT: raddr = k;
      default: ;
    endcase
  end

  // permutation store, registered read
  always_ff @(posedge clk) begin
    if (wen) begin
      perm_mem[waddr] <= wdata;
    end
    rdata <= perm_mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rng   <= '0;
      step  <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (seed_valid) begin
            rng   <= (seed_word == '0) ? RNG_W'(1) : seed_word;
            k     <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (k == LAST_IDX) begin
            step  <= LAST_IDX;
            state <= S_RNG;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_RNG: begin
          rng   <= rng_next;
          state <= S_MOD;
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_RDI;
          end
        end
        S_RDI: state <= S_RDJ;
        S_RDJ: state <= S_WRI;
        S_WRI: state <= S_WRJ;
        S_WRJ: begin
          if (step == IDX_W'(1)) begin
            step  <= '0;
            k     <= '0;
            state <= S_EMRD;
          end else begin
            step  <= step - 1'b1;
            state <= S_RNG;
          end
        end
        S_EMRD: state <= S_EMOUT;
        S_EMOUT: begin
          if (out_load) begin
            if (k == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_EMRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // swap operands
  always_ff @(posedge clk) begin
    if (state == S_MOD && mod_done) begin
      j <= mod_rem[IDX_W-1:0];
    end
    if (state == S_RDJ) begin
      held <= rdata;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (out_load) begin
      entry_valid <= 1'b1;
    end else if (entry_ready) begin
      entry_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      position    <= FIELD_W'(k);
      entry_value <= rdata;
      last_entry  <= (k == LAST_IDX);
    end
  end

  // checks
  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("modulo finished outside its wait state");

  a_j_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDI) |-> (j <= step))
    else $error("swap partner beyond current step");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (entry_valid && last_entry) |-> (position == FIELD_W'(STAGE_COUNT - 1)))
    else $error("last entry flagged at wrong position");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    seed_ready |-> (step == '0))
    else $error("step counter not cleared while idle");

endmodule
